// ----- hdl/riac_pkg.sv -----
package riac_pkg;

	localparam int FREE_DEPTH = 1024;
	localparam int ADDR_W     = $clog2(FREE_DEPTH);
	localparam int CNT_W      = $clog2(FREE_DEPTH + 1);

	localparam int ID_W      = 16;
	localparam int NEXT_W    = ID_W + 1;
	localparam int STAT_W    = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_RANGE_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_END   = 2'd1;

endpackage

// ----- hdl/range_id_allocator_core.sv -----
// Identifier allocator over a configured range. An allocate (tuser 0) pops the most
// recently freed identifier from a LIFO stack of FREE_DEPTH entries held in one
// synchronous RAM, or, with the stack empty, issues the next never-issued value of
// the range and reports exhaustion (status 1) once that counter is past range_end.
// A free (tuser 1) pushes tdata onto the stack, or drops it with status 2 when the
// stack is full. Each request gives exactly one result: tdata is the granted
// identifier (0 unless an allocate succeeded), tuser the status. Frees and counter
// allocates are written straight to the result register; an allocate from the stack
// waits on the registered stack RAM read. A new request is taken while the previous
// result is being accepted downstream. Writing range_start reloads the counter and
// empties the stack; write registers only while no request is outstanding.
module range_id_allocator_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [riac_pkg::ID_W-1:0]       s_tdata,   // port_in
	input  logic                            s_tuser,   // mode
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [riac_pkg::ID_W-1:0]       m_tdata,   // port_out
	output logic [riac_pkg::STAT_W-1:0]     m_tuser,   // status
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [riac_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [riac_pkg::ID_W-1:0]       cfg_data
);

	import riac_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_POP  = 1'b1;

	logic                state_q;
	logic [CNT_W-1:0]    count_q;
	logic [NEXT_W-1:0]   next_q;
	logic [ID_W-1:0]     range_end_q;
	logic                m_tvalid_q;
	logic [ID_W-1:0]     m_tdata_q;
	logic [STAT_W-1:0]   m_tuser_q;

	logic                accept;
	logic                stack_empty;
	logic                stack_full;
	logic                exhausted;
	logic                do_pop;
	logic                do_push;
	logic [CNT_W-1:0]    count_dec;
	logic [ID_W-1:0]     rd_data;
	logic [ID_W-1:0]     res_data;
	logic [STAT_W-1:0]   res_stat;

	assign s_tready    = (state_q == ST_IDLE) && (!m_tvalid_q || m_tready);
	assign accept      = s_tvalid && s_tready;
	assign cfg_ready   = 1'b1;
	assign stack_empty = (count_q == '0);
	assign stack_full  = (count_q == CNT_W'(FREE_DEPTH));
	assign exhausted   = (next_q > {1'b0, range_end_q});
	assign count_dec   = count_q - 1'b1;
	assign do_pop      = accept && (s_tuser == MODE_ALLOC) && !stack_empty;
	assign do_push     = accept && (s_tuser == MODE_FREE) && !stack_full;

	riac_ram #(
		.DEPTH(FREE_DEPTH),
		.WIDTH(ID_W)
	) u_stack (
		.clk    (clk),
		.wr_en  (do_push),
		.wr_addr(count_q[ADDR_W-1:0]),
		.wr_data(s_tdata),
		.rd_en  (do_pop),
		.rd_addr(count_dec[ADDR_W-1:0]),
		.rd_data(rd_data)
	);

	always_comb begin
		res_data = '0;
		res_stat = STAT_OK;
		if (s_tuser == MODE_ALLOC) begin
			if (exhausted) begin
				res_stat = STAT_EXHAUSTED;
			end else begin
				res_data = next_q[ID_W-1:0];
			end
		end else if (stack_full) begin
			res_stat = STAT_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			next_q      <= '0;
			range_end_q <= '1;
			m_tvalid_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (do_pop) begin
						state_q <= ST_POP;
						count_q <= count_dec;
					end else if (do_push) begin
						count_q <= count_q + 1'b1;
					end else if (accept && (s_tuser == MODE_ALLOC) && !exhausted) begin
						next_q <= next_q + 1'b1;
					end
				end
				ST_POP: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if ((accept && !do_pop) || (state_q == ST_POP)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_RANGE_START: begin
						next_q  <= {1'b0, cfg_data};
						count_q <= '0;
					end
					REG_RANGE_END: begin
						range_end_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_POP) begin
			m_tdata_q <= rd_data;
			m_tuser_q <= STAT_OK;
		end else if (accept && !do_pop) begin
			m_tdata_q <= res_data;
			m_tuser_q <= res_stat;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ----- hdl/riac_ram.sv -----
module riac_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- hdl/riac_checker.sv -----
module riac_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            s_tuser,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [riac_pkg::ID_W-1:0]       m_tdata,
	input logic [riac_pkg::STAT_W-1:0]     m_tuser
);

	import riac_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_stat_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == STAT_OK) || (m_tuser == STAT_EXHAUSTED)
			|| (m_tuser == STAT_FULL))
		else $error("undefined status code");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != STAT_OK) |-> (m_tdata == '0))
		else $error("failed transaction carries an identifier");

	a_out_drained: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> !m_tvalid || m_tready)
		else $error("request taken while a result is stalled");

	a_free_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == MODE_FREE) |=> m_tvalid
			&& ((m_tuser == STAT_OK) || (m_tuser == STAT_FULL)) && (m_tdata == '0))
		else $error("free transaction gave a wrong result");

endmodule

bind range_id_allocator_core riac_checker u_riac_checker (.*);

// ----- sim/tb_range_id_allocator_core.sv -----
`timescale 1ns / 100ps

module tb_range_id_allocator_core;
	import riac_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [STAT_W-1:0] status;
	} grant_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [ID_W-1:0]      s_tdata = '0;
	logic                 s_tuser = MODE_ALLOC;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [ID_W-1:0]      m_tdata;
	logic [STAT_W-1:0]    m_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_RANGE_START;
	logic [ID_W-1:0]      cfg_data = '0;

	// allocator state as predicted
	logic [ID_W-1:0]   range_hi = '1;
	logic [ID_W-1:0]   free_ids [FREE_DEPTH];
	int                free_cnt = 0;
	logic [NEXT_W-1:0] next_id = '0;

	grant_t grant_q [$];
	int     errors = 0;
	int     send_idle_pct = 0;
	int     ready_stall_pct = 0;
	int     hold_left = 0;

	range_id_allocator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#4ms;
		$display("== FAIL ==");
		$finish;
	end

	function automatic grant_t predict_grant(input logic mode, input logic [ID_W-1:0] id_in);
		grant_t g;
		g.id = '0;
		g.status = STAT_OK;
		if (mode == MODE_ALLOC) begin
			if (free_cnt > 0) begin
				free_cnt--;
				g.id = free_ids[free_cnt];
			end else if (next_id > {1'b0, range_hi}) begin
				g.status = STAT_EXHAUSTED;
			end else begin
				g.id = next_id[ID_W-1:0];
				next_id++;
			end
		end else begin
			if (free_cnt >= FREE_DEPTH) begin
				g.status = STAT_FULL;
			end else begin
				free_ids[free_cnt] = id_in;
				free_cnt++;
			end
		end
		return g;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ID_W-1:0] val);
		if (idx == REG_RANGE_START) begin
			next_id = {1'b0, val};
			free_cnt = 0;
		end else if (idx == REG_RANGE_END) begin
			range_hi = val;
		end
	endfunction

	always @(posedge clk) begin : monitor
		grant_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				apply_reg(cfg_index, cfg_data);
			if (s_tvalid && s_tready)
				grant_q.push_back(predict_grant(s_tuser, s_tdata));
			if (m_tvalid && m_tready) begin
				if (grant_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected transaction, expected none, got id %h status %0d",
						$time, m_tdata, m_tuser);
				end else begin
					want = grant_q.pop_front();
					if (m_tdata !== want.id) begin
						errors++;
						$display("%0t: id mismatch, expected %h, got %h",
							$time, want.id, m_tdata);
					end
					if (m_tuser !== want.status) begin
						errors++;
						$display("%0t: status mismatch, expected %0d, got %0d",
							$time, want.status, m_tuser);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= ready_stall_pct);
		end
	end

	task automatic send_req(input logic mode, input logic [ID_W-1:0] id);
		int gap = 0;
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= id;
		do @(posedge clk); while (!s_tready);
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// leave valid high when more writes follow
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ID_W-1:0] val,
			input bit more = 1'b0);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (!more)
			cfg_valid <= 1'b0;
	endtask

	task automatic wait_results();
		if (s_tvalid)
			s_tvalid <= 1'b0;
		do @(posedge clk); while (grant_q.size() != 0);
	endtask

	task automatic set_idling(input int send_pct, input int stall_pct);
		send_idle_pct = send_pct;
		ready_stall_pct = stall_pct;
	endtask

	task automatic test_directed();
		set_idling(0, 0);
		send_req(MODE_ALLOC, 16'h0000);
		send_req(MODE_ALLOC, 16'hFFFF);
		send_req(MODE_FREE, 16'hFFFF);
		send_req(MODE_FREE, 16'h0000);
		send_req(MODE_ALLOC, 16'h0000);
		send_req(MODE_ALLOC, 16'h0000);
		send_req(MODE_ALLOC, 16'h0000);
		wait_results();
		write_reg(REG_RANGE_END, 16'd3);
		send_req(MODE_ALLOC, 16'h0000);
		send_req(MODE_ALLOC, 16'h0000);
		// lower the end below the counter
		wait_results();
		write_reg(REG_RANGE_END, 16'd1);
		send_req(MODE_ALLOC, 16'h0000);
		send_req(MODE_FREE, 16'hA5A5);
		send_req(MODE_ALLOC, 16'h0000);
		send_req(MODE_ALLOC, 16'h0000);
		// unmapped indexes must change nothing
		wait_results();
		write_reg(REG_SPARE_2, 16'h0000, 1'b1);
		write_reg(REG_SPARE_3, 16'hFFFF);
		send_req(MODE_ALLOC, 16'h0000);
		wait_results();
		write_reg(REG_RANGE_END, 16'hFFFF, 1'b1);
		write_reg(REG_RANGE_START, 16'hFFFF);
		send_req(MODE_ALLOC, 16'h0000);
		send_req(MODE_ALLOC, 16'h0000);
		wait_results();
		write_reg(REG_RANGE_END, 16'h0000, 1'b1);
		write_reg(REG_RANGE_START, 16'h0000);
		send_req(MODE_ALLOC, 16'h0000);
		send_req(MODE_ALLOC, 16'h0000);
		// start above end
		wait_results();
		write_reg(REG_RANGE_END, 16'd60, 1'b1);
		write_reg(REG_RANGE_START, 16'd500);
		send_req(MODE_ALLOC, 16'h0000);
		send_req(MODE_FREE, 16'h0007);
		send_req(MODE_ALLOC, 16'h0000);
		// a start write empties the stack
		send_req(MODE_FREE, 16'h1234);
		wait_results();
		write_reg(REG_RANGE_END, 16'd300, 1'b1);
		write_reg(REG_RANGE_START, 16'd200);
		send_req(MODE_ALLOC, 16'h0000);
		wait_results();
	endtask

	task automatic test_stack_full();
		int i;
		set_idling(8, 8);
		write_reg(REG_RANGE_END, 16'hFFFF, 1'b1);
		write_reg(REG_RANGE_START, 16'h8000);
		for (i = 0; i < FREE_DEPTH + 4; i++)
			send_req(MODE_FREE, ID_W'($urandom));
		for (i = 0; i < 40; i++)
			send_req($urandom_range(1) ? MODE_FREE : MODE_ALLOC, ID_W'($urandom));
		for (i = 0; i < 80; i++)
			send_req(MODE_ALLOC, ID_W'($urandom));
		wait_results();
	endtask

	task automatic test_random_phases();
		int send_pct [4] = '{0, 78, 0, 8};
		int stall_pct [4] = '{0, 0, 78, 8};
		int p;
		int i;
		logic [ID_W-1:0] lo;
		logic [ID_W-1:0] hi;
		logic mode;
		logic [ID_W-1:0] id;
		for (p = 0; p < 4; p++) begin
			case (p)
				0: begin
					lo = 16'd0;
					hi = 16'd40;
				end
				1: begin
					lo = 16'd65500;
					hi = 16'hFFFF;
				end
				2: begin
					lo = ID_W'($urandom);
					hi = lo + ID_W'($urandom_range(100));
				end
				default: begin
					lo = 16'd1000;
					hi = 16'd900;
				end
			endcase
			set_idling(send_pct[p], stall_pct[p]);
			write_reg(REG_RANGE_END, hi, 1'b1);
			write_reg(REG_RANGE_START, lo);
			for (i = 0; i < 180; i++) begin
				mode = ($urandom_range(99) < 55) ? MODE_ALLOC : MODE_FREE;
				id = $urandom_range(1) ? lo + ID_W'($urandom_range(63)) : ID_W'($urandom);
				send_req(mode, id);
			end
			wait_results();
		end
	endtask

	task automatic test_backpressure();
		int i;
		set_idling(0, 0);
		write_reg(REG_RANGE_END, 16'h0120, 1'b1);
		write_reg(REG_RANGE_START, 16'h0100);
		hold_left = HOLD_CYCLES;
		for (i = 0; i < 40; i++)
			send_req($urandom_range(1) ? MODE_FREE : MODE_ALLOC, ID_W'($urandom));
		// pause until everything has drained
		wait_results();
		set_idling(8, 8);
		for (i = 0; i < 20; i++)
			send_req($urandom_range(1) ? MODE_FREE : MODE_ALLOC, ID_W'($urandom));
		wait_results();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_stack_full();
		test_random_phases();
		test_backpressure();
		repeat (10) @(posedge clk);
		if (grant_q.size() != 0) begin
			errors++;
			$display("%0t: missing transaction, expected id %h status %0d, got none",
				$time, grant_q[0].id, grant_q[0].status);
		end
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
